// ===== rtl/mf3_pkg.sv =====
// Shared types, constants and compare helpers for the 3x3 median filter.
// No dependencies; imported by mf3_median, median_filter_3x3 and the bench.
package mf3_pkg;

  localparam int PIX_BITS      = 8;
  localparam int WIDTH_BITS    = 10;
  localparam int HEIGHT_BITS   = 13;
  localparam int ROW_BITS      = 12;
  localparam int MAX_HEIGHT    = 4096;
  localparam int CFG_ADDR_BITS = 2;
  localparam int CFG_DATA_BITS = 13;

  typedef logic [PIX_BITS-1:0] pixel_t;

  typedef enum logic {
    MODE_PIXEL = 1'b0,
    MODE_DRAIN = 1'b1
  } mode_t;

  typedef enum logic [CFG_ADDR_BITS-1:0] {
    REG_IMAGE_WIDTH  = 2'd0,
    REG_IMAGE_HEIGHT = 2'd1
  } cfg_reg_t;

  typedef struct packed {
    mode_t  mode;
    pixel_t in_pixel;
  } in_item_t;

  typedef struct packed {
    pixel_t out_pixel;
    logic   frame_last;
  } out_item_t;

  // One window column, newest row first.
  typedef struct packed {
    pixel_t row0;
    pixel_t row1;
    pixel_t row2;
  } col3_t;

  typedef struct packed {
    pixel_t lo;
    pixel_t mid;
    pixel_t hi;
  } sorted3_t;

  function automatic pixel_t min2(input pixel_t a, input pixel_t b);
    return (a < b) ? a : b;
  endfunction

  function automatic pixel_t max2(input pixel_t a, input pixel_t b);
    return (a < b) ? b : a;
  endfunction

  function automatic pixel_t med3(input pixel_t a, input pixel_t b, input pixel_t c);
    return max2(min2(a, b), min2(max2(a, b), c));
  endfunction

  function automatic sorted3_t sort3(input pixel_t a, input pixel_t b, input pixel_t c);
    sorted3_t s;
    s.lo  = min2(min2(a, b), c);
    s.mid = med3(a, b, c);
    s.hi  = max2(max2(a, b), c);
    return s;
  endfunction

endpackage

// ===== rtl/median_filter_3x3.sv =====
// Top level of the streaming 3x3 median filter: counters, line memory, result memory
// and output queue. Depends on mf3_pkg and mf3_median.
//
// Usage:
//   Configure image_width / image_height on the cfg_ port while the block is idle;
//   any write to a known register restarts the frame (positions and pending count
//   cleared, stored pixels kept). Unknown register indexes are ignored.
//   Feed pixels in raster order on in_ (mode = pixel); frames follow each other
//   without a gap. Send drain items after the last pixel to flush what is pending.
//   Each interior pixel comes out as the median of its 3x3 neighbourhood, border
//   pixels unchanged; frame_last marks the bottom right pixel of each frame.
// Throughput: one item per clock, sustained, when out_ready stays high.
// Release: a result leaves on out_ after the transfer of the item that releases it
//   (one line plus one pixel behind the input, or a drain item), once the per-column
//   line memory read-modify-write and then the result memory read have run.
// Stall: results queue in an eight-entry buffer; in_ready drops only when eight
//   results are outstanding, so a waiting result never blocks the next transfer.
// Reset: counters, pointers and valid bits clear; the default size is 512x512.
//   Neither memory is cleared: no value read before it is written reaches out_.
module median_filter_3x3 #(
  parameter int MAX_WIDTH = 512
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_wr_en,
  input  logic [mf3_pkg::CFG_ADDR_BITS-1:0] cfg_index,
  input  logic [mf3_pkg::CFG_DATA_BITS-1:0] cfg_wdata,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  mf3_pkg::in_item_t                 in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output mf3_pkg::out_item_t                out_data
);
  import mf3_pkg::*;

  localparam int CW         = $clog2(MAX_WIDTH);          // column index
  localparam int CW1        = $clog2(MAX_WIDTH + 1);      // effective width
  localparam int PW         = $clog2(MAX_WIDTH + 3);      // pending count
  localparam int AW         = $clog2(2 * MAX_WIDTH + 3);  // pixel sequence number
  localparam int EW         = (CW1 > WIDTH_BITS) ? CW1 : WIDTH_BITS;
  localparam int B_DEPTH    = 2 ** AW;
  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int OCC_W      = $clog2(FIFO_DEPTH + 1);
  localparam int TK_STAGES  = 4;
  localparam int PX_STAGES  = 3;

  typedef struct packed {
    pixel_t up1;   // pixel one row above
    pixel_t up2;   // pixel two rows above
  } line_word_t;

  typedef struct packed {
    pixel_t pix;   // the pixel with this sequence number
    pixel_t med;   // window median completed by this pixel
  } slot_t;

  typedef struct packed {
    pixel_t          pixel;
    logic [CW-1:0]   col;
    logic [AW-1:0]   seq;
  } pix_stage_t;

  typedef struct packed {
    logic          inner;
    logic          last;
    logic [AW-1:0] addr;
  } tok_t;

  // Configuration and position state
  logic [WIDTH_BITS-1:0]  image_width_r,  image_width_nxt;
  logic [HEIGHT_BITS-1:0] image_height_r, image_height_nxt;
  logic [ROW_BITS-1:0]    in_row_r,  in_row_nxt;
  logic [CW-1:0]          in_col_r,  in_col_nxt;
  logic [ROW_BITS-1:0]    out_row_r, out_row_nxt;
  logic [CW-1:0]          out_col_r, out_col_nxt;
  logic [PW-1:0]          pend_r,    pend_nxt;
  logic [AW-1:0]          wr_ptr_r,  wr_ptr_nxt;
  logic [AW-1:0]          rd_ptr_r,  rd_ptr_nxt;

  logic [EW-1:0]          w_ext;
  logic [CW1-1:0]         eff_w;
  logic [HEIGHT_BITS-1:0] eff_h;
  logic [PW-1:0]          w_p;

  logic                   accept, is_pix, restart;
  logic [PW-1:0]          pend_a;
  logic                   try_emit, out_inner, lr_ok, emit, out_last;
  logic [AW-1:0]          tok_addr;
  logic [CW1-1:0]         in_col_inc,  out_col_inc;
  logic [HEIGHT_BITS-1:0] in_row_inc,  out_row_inc;
  logic [CW-1:0]          in_col_adv,  out_col_adv;
  logic [ROW_BITS-1:0]    in_row_adv,  out_row_adv;

  // Pixel path
  line_word_t mem_a [MAX_WIDTH];
  line_word_t a_q_r;
  line_word_t fwd_data_r;
  logic       fwd_hit_r;
  line_word_t col_word;
  line_word_t a_wdata;
  col3_t      win_col;
  pixel_t     median;

  logic       p_vld_r [PX_STAGES];
  pix_stage_t p_r     [PX_STAGES];

  slot_t      mem_b [B_DEPTH];
  slot_t      bq_r;

  // Result path
  logic       tk_vld_r [TK_STAGES];
  tok_t       tk_r     [TK_STAGES];
  logic       tkb_vld_r;
  tok_t       tkb_r;

  out_item_t            fifo_mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0]   fifo_wp_r, fifo_rp_r;
  logic [OCC_W-1:0]     fifo_cnt_r;
  logic [OCC_W-1:0]     occ_r, occ_nxt;
  out_item_t            push_item;
  logic                 pop;

  // Clamp the registers to their legal ranges: zero acts as one.
  always_comb begin
    w_ext = EW'(image_width_r);
    if (w_ext == '0) begin
      eff_w = CW1'(1);
    end else if (w_ext > EW'(MAX_WIDTH)) begin
      eff_w = CW1'(MAX_WIDTH);
    end else begin
      eff_w = CW1'(w_ext);
    end
    if (image_height_r == '0) begin
      eff_h = HEIGHT_BITS'(1);
    end else if (image_height_r > HEIGHT_BITS'(MAX_HEIGHT)) begin
      eff_h = HEIGHT_BITS'(MAX_HEIGHT);
    end else begin
      eff_h = image_height_r;
    end
    w_p = PW'(eff_w);
  end

  assign accept = in_valid && in_ready;
  assign is_pix = (in_data.mode == MODE_PIXEL);

  // Raster advance of the input and output positions
  always_comb begin
    in_col_inc  = CW1'(in_col_r) + CW1'(1);
    in_row_inc  = HEIGHT_BITS'(in_row_r) + HEIGHT_BITS'(1);
    out_col_inc = CW1'(out_col_r) + CW1'(1);
    out_row_inc = HEIGHT_BITS'(out_row_r) + HEIGHT_BITS'(1);
    if (in_col_inc >= eff_w) begin
      in_col_adv = '0;
      in_row_adv = (in_row_inc >= eff_h) ? '0 : in_row_inc[ROW_BITS-1:0];
    end else begin
      in_col_adv = in_col_inc[CW-1:0];
      in_row_adv = in_row_r;
    end
    if (out_col_inc >= eff_w) begin
      out_col_adv = '0;
      out_row_adv = (out_row_inc >= eff_h) ? '0 : out_row_inc[ROW_BITS-1:0];
    end else begin
      out_col_adv = out_col_inc[CW-1:0];
      out_row_adv = out_row_r;
    end
  end

  // Release decision: depends on counters only, never on pixel data.
  always_comb begin
    pend_a    = is_pix ? pend_r + PW'(1) : pend_r;
    try_emit  = is_pix ? (pend_a > w_p + PW'(1)) : 1'b1;
    out_inner = (out_row_r != '0) && (out_col_r != '0) &&
                (out_row_inc < eff_h) && (out_col_inc < eff_w);
    // Lower right neighbour of the oldest pending pixel has arrived
    lr_ok     = (pend_a >= w_p + PW'(2));
    emit      = accept && try_emit && (pend_a != '0) && (!out_inner || lr_ok);
    out_last  = (HEIGHT_BITS'(out_row_r) == eff_h - HEIGHT_BITS'(1)) &&
                (CW1'(out_col_r) == eff_w - CW1'(1));
    // Interior results sit in the slot of the pixel that completed the window
    tok_addr  = out_inner ? rd_ptr_r + AW'(eff_w) + AW'(1) : rd_ptr_r;
  end

  // Next state of configuration and counters
  always_comb begin
    image_width_nxt  = image_width_r;
    image_height_nxt = image_height_r;
    in_row_nxt       = in_row_r;
    in_col_nxt       = in_col_r;
    out_row_nxt      = out_row_r;
    out_col_nxt      = out_col_r;
    pend_nxt         = pend_r;
    wr_ptr_nxt       = wr_ptr_r;
    rd_ptr_nxt       = rd_ptr_r;
    restart          = 1'b0;
    if (cfg_wr_en) begin
      case (cfg_index)
        REG_IMAGE_WIDTH: begin
          image_width_nxt = cfg_wdata[WIDTH_BITS-1:0];
          restart         = 1'b1;
        end
        REG_IMAGE_HEIGHT: begin
          image_height_nxt = cfg_wdata[HEIGHT_BITS-1:0];
          restart          = 1'b1;
        end
        default: begin
          restart = 1'b0;
        end
      endcase
    end
    if (restart) begin
      // Drop pending pixels, keep what is stored
      in_row_nxt  = '0;
      in_col_nxt  = '0;
      out_row_nxt = '0;
      out_col_nxt = '0;
      pend_nxt    = '0;
      rd_ptr_nxt  = wr_ptr_r;
    end else if (accept) begin
      pend_nxt = pend_a - PW'(emit);
      if (is_pix) begin
        in_row_nxt = in_row_adv;
        in_col_nxt = in_col_adv;
        wr_ptr_nxt = wr_ptr_r + AW'(1);
      end
      if (emit) begin
        out_row_nxt = out_row_adv;
        out_col_nxt = out_col_adv;
        rd_ptr_nxt  = rd_ptr_r + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_width_r  <= WIDTH_BITS'(512);
      image_height_r <= HEIGHT_BITS'(512);
      in_row_r       <= '0;
      in_col_r       <= '0;
      out_row_r      <= '0;
      out_col_r      <= '0;
      pend_r         <= '0;
      wr_ptr_r       <= '0;
      rd_ptr_r       <= '0;
    end else begin
      image_width_r  <= image_width_nxt;
      image_height_r <= image_height_nxt;
      in_row_r       <= in_row_nxt;
      in_col_r       <= in_col_nxt;
      out_row_r      <= out_row_nxt;
      out_col_r      <= out_col_nxt;
      pend_r         <= pend_nxt;
      wr_ptr_r       <= wr_ptr_nxt;
      rd_ptr_r       <= rd_ptr_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Pixel path: per-column line memory read-modify-write, window, median, slot.
  // ---------------------------------------------------------------------------

  // Back-to-back pixels in one column (width one) read before the write lands:
  // take the word being written instead.
  assign col_word = fwd_hit_r ? fwd_data_r : a_q_r;
  assign a_wdata  = '{up1: p_r[0].pixel, up2: col_word.up1};
  assign win_col  = '{row0: p_r[0].pixel, row1: col_word.up1, row2: col_word.up2};

  always_ff @(posedge clk) begin
    a_q_r      <= mem_a[in_col_r];
    fwd_hit_r  <= p_vld_r[0] && (p_r[0].col == in_col_r);
    fwd_data_r <= a_wdata;
    if (p_vld_r[0]) begin
      mem_a[p_r[0].col] <= a_wdata;
    end
  end

  mf3_median u_median (
    .clk      (clk),
    .shift_en (p_vld_r[0]),
    .col_i    (win_col),
    .median_o (median)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < PX_STAGES; i++) begin
        p_vld_r[i] <= 1'b0;
      end
    end else begin
      p_vld_r[0] <= accept && is_pix;
      for (int i = 1; i < PX_STAGES; i++) begin
        p_vld_r[i] <= p_vld_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    p_r[0] <= '{pixel: in_data.in_pixel, col: in_col_r, seq: wr_ptr_r};
    for (int i = 1; i < PX_STAGES; i++) begin
      p_r[i] <= p_r[i-1];
    end
  end

  // Store pixel and the median it completes under the pixel's sequence number
  always_ff @(posedge clk) begin
    if (p_vld_r[PX_STAGES-1]) begin
      mem_b[p_r[PX_STAGES-1].seq] <= '{pix: p_r[PX_STAGES-1].pixel, med: median};
    end
  end

  // ---------------------------------------------------------------------------
  // Result path: delay the release token until its slot is written, then read.
  // ---------------------------------------------------------------------------

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < TK_STAGES; i++) begin
        tk_vld_r[i] <= 1'b0;
      end
      tkb_vld_r <= 1'b0;
    end else begin
      tk_vld_r[0] <= emit;
      for (int i = 1; i < TK_STAGES; i++) begin
        tk_vld_r[i] <= tk_vld_r[i-1];
      end
      tkb_vld_r <= tk_vld_r[TK_STAGES-1];
    end
  end

  always_ff @(posedge clk) begin
    tk_r[0] <= '{inner: out_inner, last: out_last, addr: tok_addr};
    for (int i = 1; i < TK_STAGES; i++) begin
      tk_r[i] <= tk_r[i-1];
    end
    tkb_r <= tk_r[TK_STAGES-1];
    bq_r  <= mem_b[tk_r[TK_STAGES-1].addr];
  end

  assign push_item = '{out_pixel:  tkb_r.inner ? bq_r.med : bq_r.pix,
                       frame_last: tkb_r.last};

  // Output queue; occupancy counts every result released but not yet transferred
  assign pop       = out_valid && out_ready;
  assign out_valid = (fifo_cnt_r != '0);
  assign out_data  = fifo_mem[fifo_rp_r];
  assign in_ready  = (occ_r < OCC_W'(FIFO_DEPTH));
  assign occ_nxt   = occ_r + OCC_W'(emit) - OCC_W'(pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fifo_wp_r  <= '0;
      fifo_rp_r  <= '0;
      fifo_cnt_r <= '0;
      occ_r      <= '0;
    end else begin
      occ_r      <= occ_nxt;
      fifo_cnt_r <= fifo_cnt_r + OCC_W'(tkb_vld_r) - OCC_W'(pop);
      if (tkb_vld_r) begin
        fifo_wp_r <= fifo_wp_r + FIFO_AW'(1);
      end
      if (pop) begin
        fifo_rp_r <= fifo_rp_r + FIFO_AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (tkb_vld_r) begin
      fifo_mem[fifo_wp_r] <= push_item;
    end
  end

endmodule

// ===== rtl/mf3_median.sv =====
// Sliding 3x3 window of sorted columns and a two-stage median network.
// Depends on mf3_pkg for pixel types and compare helpers.
module mf3_median (
  input  logic           clk,
  input  logic           shift_en,
  input  mf3_pkg::col3_t col_i,
  output mf3_pkg::pixel_t median_o
);
  import mf3_pkg::*;

  sorted3_t win_r [3];
  pixel_t   lo_max_r;
  pixel_t   mid_med_r;
  pixel_t   hi_min_r;

  // Sort each column as it enters, shift the window on every new pixel.
  always_ff @(posedge clk) begin
    if (shift_en) begin
      win_r[2] <= win_r[1];
      win_r[1] <= win_r[0];
      win_r[0] <= sort3(col_i.row0, col_i.row1, col_i.row2);
    end
  end

  // Largest low, median of mids, smallest high; their median is the window median.
  always_ff @(posedge clk) begin
    lo_max_r  <= max2(max2(win_r[0].lo, win_r[1].lo), win_r[2].lo);
    mid_med_r <= med3(win_r[0].mid, win_r[1].mid, win_r[2].mid);
    hi_min_r  <= min2(min2(win_r[0].hi, win_r[1].hi), win_r[2].hi);
  end

  assign median_o = med3(lo_max_r, mid_med_r, hi_min_r);

endmodule

// ===== bench/tb.sv =====
// Self-checking bench for median_filter_3x3: streams pixels and drain ticks over many frame
// sizes, predicts every filtered pixel and checks each out_ transfer against that prediction.
// Depends on mf3_pkg and the median_filter_3x3 RTL.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mf3_pkg::*;

  localparam int MAX_W         = 512;
  localparam int RING_DEPTH    = 2 * MAX_W + 3;  // two lines plus a few pixels of history
  localparam int MID_TAP       = 4;              // fifth smallest of nine
  localparam int SETTLE_CYCLES = 20;             // comfortably past the output latency
  localparam int ITEM_BUDGET   = 1950;           // transfers over the whole run
  localparam int STAGE_ITEMS   = 430;            // transfers per idling stage before the last
  localparam int TAIL_ITEMS    = 50;             // kept back for the closing frame

  // Register indexes the block does not decode; writes to them must change nothing.
  localparam logic [CFG_ADDR_BITS-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_ADDR_BITS-1:0] REG_SPARE_B = 2'd3;

  logic                     clk       = 1'b0;
  logic                     rst_n     = 1'b0;
  logic                     cfg_wr_en = 1'b0;
  logic [CFG_ADDR_BITS-1:0] cfg_index = '0;
  logic [CFG_DATA_BITS-1:0] cfg_wdata = '0;
  logic                     in_valid  = 1'b0;
  logic                     in_ready;
  in_item_t                 in_data   = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  out_item_t                out_data;

  median_filter_3x3 #(.MAX_WIDTH(MAX_W)) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #6 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Filter predictor: its own copy of the size registers, pixel history and the
  // position of the next pixel to leave.
  // ---------------------------------------------------------------------------
  logic [WIDTH_BITS-1:0]  width_reg  = WIDTH_BITS'(512);
  logic [HEIGHT_BITS-1:0] height_reg = HEIGHT_BITS'(512);
  pixel_t                 px_history [RING_DEPTH] = '{default: '0};
  int unsigned            hist_wr    = 0;
  int unsigned            held_px    = 0;  // pixels taken in but not yet released
  int unsigned            emit_row   = 0;
  int unsigned            emit_col   = 0;

  in_item_t    stream_q [$];       // transfers waiting for the driver
  out_item_t   filtered_px_q [$];  // results owed by the block, oldest first

  int unsigned mismatch_count = 0;
  int unsigned items_queued   = 0;
  int          idle_stage     = 0;
  int unsigned send_calm      = 0;
  int unsigned recv_calm      = 0;

  function automatic int unsigned clamp_width(int unsigned w);
    if (w == 0) return 1;
    if (w > MAX_W) return MAX_W;
    return w;
  endfunction

  function automatic int unsigned clamp_height(int unsigned h);
    if (h == 0) return 1;
    if (h > MAX_HEIGHT) return MAX_HEIGHT;
    return h;
  endfunction

  // Pixel taken in 'back' pixels before the newest one; drain transfers do not count.
  function automatic pixel_t history_back(int unsigned back);
    return px_history[(hist_wr + RING_DEPTH - 1 - back % RING_DEPTH) % RING_DEPTH];
  endfunction

  function automatic pixel_t fifth_smallest(pixel_t taps [9]);
    pixel_t s [9];
    pixel_t v;
    int     j;
    s = taps;
    for (int i = 1; i < 9; i++) begin
      v = s[i];
      j = i - 1;
      while (j >= 0 && s[j] > v) begin
        s[j+1] = s[j];
        j--;
      end
      s[j+1] = v;
    end
    return s[MID_TAP];
  endfunction

  // Release the oldest held pixel if its whole neighbourhood is known.
  function automatic bit release_held(output out_item_t res);
    int unsigned w;
    int unsigned h;
    int unsigned d;
    bit          interior;
    pixel_t      taps [9];
    res = '0;
    w = clamp_width(width_reg);
    h = clamp_height(height_reg);
    if (held_px == 0) return 1'b0;
    d = held_px - 1;
    interior = emit_row >= 1 && emit_col >= 1 && emit_row + 1 < h && emit_col + 1 < w;
    if (interior) begin
      // lower right neighbour not in yet: nothing leaves
      if (d < w + 1) return 1'b0;
      for (int i = 0; i < 3; i++)
        for (int k = 0; k < 3; k++)
          taps[i*3 + k] = history_back(d + w + 1 - (i*w + k));
      res.out_pixel = fifth_smallest(taps);
    end else begin
      res.out_pixel = history_back(d);
    end
    res.frame_last = (emit_row == h - 1) && (emit_col == w - 1);
    emit_col++;
    if (emit_col >= w) begin
      emit_col = 0;
      emit_row++;
      if (emit_row >= h) emit_row = 0;
    end
    held_px--;
    return 1'b1;
  endfunction

  function automatic bit filter_accept(in_item_t it, output out_item_t res);
    res = '0;
    if (it.mode == MODE_PIXEL) begin
      px_history[hist_wr] = it.in_pixel;
      hist_wr = (hist_wr + 1) % RING_DEPTH;
      held_px++;
      if (held_px > clamp_width(width_reg) + 1) return release_held(res);
      return 1'b0;
    end
    return release_held(res);
  endfunction

  // A decoded write restarts the frame and drops whatever is held.
  function automatic void apply_reg(logic [CFG_ADDR_BITS-1:0] idx,
                                    logic [CFG_DATA_BITS-1:0] val);
    case (idx)
      REG_IMAGE_WIDTH:  width_reg = val[WIDTH_BITS-1:0];
      REG_IMAGE_HEIGHT: height_reg = val[HEIGHT_BITS-1:0];
      default:          return;
    endcase
    held_px  = 0;
    emit_row = 0;
    emit_col = 0;
  endfunction

  // ---------------------------------------------------------------------------
  // Flow control: idle percentages follow the stage; calm stretches switch
  // idling off for a while so that long unbroken bursts also happen.
  // ---------------------------------------------------------------------------
  function automatic bit hold_back(int pct, inout int unsigned calm);
    if (calm != 0) begin
      calm--;
      return 1'b0;
    end
    if ($urandom_range(0, 199) == 0) begin
      calm = $urandom_range(20, 80);
      return 1'b0;
    end
    return $urandom_range(0, 99) < pct;
  endfunction

  function automatic int send_idle_pct();
    return (idle_stage == 0) ? 10 : (idle_stage == 1) ? 54 : 0;
  endfunction

  function automatic int recv_idle_pct();
    return (idle_stage == 0) ? 54 : (idle_stage == 1) ? 10 : 0;
  endfunction

  task automatic report_mismatch(string msg);
    mismatch_count++;
    $display("mismatch at %0t: %s", $time, msg);
  endtask

  // Driver: on each transfer, run the predictor; then hold the item while
  // in_ready is low, otherwise present the next one or idle.
  always @(posedge clk) begin : pixel_driver
    out_item_t res;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        if (filter_accept(in_data, res)) filtered_px_q.push_back(res);
      end
      if (!in_valid || in_ready) begin
        if (stream_q.size() != 0 && !hold_back(send_idle_pct(), send_calm)) begin
          in_valid <= 1'b1;
          in_data  <= stream_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each result transfer with the oldest owed result.
  always @(posedge clk) begin : result_monitor
    out_item_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (filtered_px_q.size() == 0) begin
          report_mismatch($sformatf("result %0d arrived with none owed", out_data.out_pixel));
        end else begin
          want = filtered_px_q.pop_front();
          if (out_data.out_pixel !== want.out_pixel)
            report_mismatch($sformatf("out_pixel %0d, predicted %0d",
                                      out_data.out_pixel, want.out_pixel));
          if (out_data.frame_last !== want.frame_last)
            report_mismatch($sformatf("frame_last %0b, predicted %0b",
                                      out_data.frame_last, want.frame_last));
        end
      end
      out_ready <= !hold_back(recv_idle_pct(), recv_calm);
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic void queue_pixel(pixel_t v);
    stream_q.push_back('{mode: MODE_PIXEL, in_pixel: v});
    items_queued++;
  endfunction

  // Drain ticks carry junk in the pixel field; the block must ignore it.
  function automatic void queue_drain();
    stream_q.push_back('{mode: MODE_DRAIN, in_pixel: pixel_t'($urandom)});
    items_queued++;
  endfunction

  // Bias towards the extremes and a narrow band so that ties are common.
  function automatic pixel_t pick_pixel();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 12) return '0;
    if (r < 24) return '1;
    if (r < 44) return pixel_t'($urandom_range(100, 103));
    return pixel_t'($urandom_range(0, 255));
  endfunction

  // Wait until every transfer is out and every owed result is in, then let
  // the pipeline settle in case a held pixel is still being worked on.
  task automatic wait_quiet();
    do @(negedge clk);
    while (stream_q.size() != 0 || in_valid || filtered_px_q.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_ADDR_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    apply_reg(idx, val);
  endtask

  // Write both size registers in random order, now and then also a spare index;
  // the width write's unused upper bits are sometimes junk, which the block must drop.
  task automatic set_size(int unsigned w, int unsigned h);
    logic [CFG_DATA_BITS-1:0] wdat;
    wdat = CFG_DATA_BITS'(w);
    if ($urandom_range(0, 2) == 0)
      wdat[CFG_DATA_BITS-1:WIDTH_BITS] = (CFG_DATA_BITS-WIDTH_BITS)'($urandom_range(0, 7));
    if ($urandom_range(0, 1) == 1) begin
      write_reg(REG_IMAGE_WIDTH, wdat);
      write_reg(REG_IMAGE_HEIGHT, CFG_DATA_BITS'(h));
    end else begin
      write_reg(REG_IMAGE_HEIGHT, CFG_DATA_BITS'(h));
      write_reg(REG_IMAGE_WIDTH, wdat);
    end
    if ($urandom_range(0, 9) == 0)
      write_reg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B, CFG_DATA_BITS'($urandom));
  endtask

  // One frame size: stream the pixels with the odd early drain mixed in,
  // then optionally flush with enough drains to empty the line buffer.
  task automatic run_phase(int unsigned w, int unsigned h, int unsigned npix, bit flush);
    int unsigned span;
    wait_quiet();
    set_size(w, h);
    for (int unsigned k = 0; k < npix; k++) begin
      if ($urandom_range(0, 19) == 0) queue_drain();
      queue_pixel(pick_pixel());
    end
    if (flush) begin
      span = (npix < clamp_width(width_reg) + 1) ? npix : clamp_width(width_reg) + 1;
      repeat (span + 2) queue_drain();
    end
  endtask

  // Mostly small frames so that every row and column case comes round often;
  // a few maximum and out-of-range sizes, cut short to keep the run brief.
  task automatic random_phase();
    int unsigned w;
    int unsigned h;
    int unsigned r;
    int unsigned npix;
    r = $urandom_range(0, 99);
    if (r < 8)       w = 0;
    else if (r < 70) w = $urandom_range(1, 8);
    else if (r < 85) w = $urandom_range(9, 40);
    else if (r < 92) w = MAX_W;
    else             w = $urandom_range(MAX_W + 1, 1023);
    r = $urandom_range(0, 99);
    if (r < 8)       h = 0;
    else if (r < 75) h = $urandom_range(1, 8);
    else if (r < 90) h = $urandom_range(9, 20);
    else if (r < 95) h = MAX_HEIGHT;
    else             h = $urandom_range(MAX_HEIGHT + 1, 8191);
    npix = clamp_width(w) * clamp_height(h) * $urandom_range(1, 3);
    if (npix > 300) npix = $urandom_range(40, 300);
    else if ($urandom_range(0, 6) == 0) npix = $urandom_range(1, npix);  // broken frame
    run_phase(w, h, npix, $urandom_range(0, 6) != 0);
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    bit wide_done;
    wide_done = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Default 512x512 frame: a drain with nothing held, a few first-row
    // pixels (all border), then drains to flush them and two spare ones.
    queue_drain();
    queue_pixel('0);
    queue_pixel('1);
    queue_pixel(8'h55);
    queue_pixel(8'hAA);
    repeat (6) queue_drain();
    wait_quiet();

    // Smallest frame with an interior pixel. Drain down to the centre pixel,
    // whose lower right neighbour is still missing, so the last tick gives nothing.
    write_reg(REG_IMAGE_WIDTH, CFG_DATA_BITS'(3));
    write_reg(REG_IMAGE_HEIGHT, CFG_DATA_BITS'(3));
    queue_pixel(8'd9);
    queue_pixel(8'd1);
    queue_pixel(8'd8);
    queue_pixel(8'd2);
    queue_pixel(8'd7);
    repeat (4) queue_drain();
    wait_quiet();

    // Undecoded indexes must neither restart the frame nor change the size.
    write_reg(REG_SPARE_A, '1);
    write_reg(REG_SPARE_B, CFG_DATA_BITS'(1));
    queue_pixel(8'd3);
    queue_pixel(8'd6);
    queue_pixel(8'd4);
    queue_pixel(8'd5);
    repeat (5) queue_drain();

    // Zero width and height act as one: every pixel is a frame of its own.
    run_phase(0, 0, 12, 1'b1);

    while (items_queued < ITEM_BUDGET - TAIL_ITEMS) begin
      idle_stage = (items_queued < STAGE_ITEMS)     ? 0 :
                   (items_queued < 2 * STAGE_ITEMS) ? 1 : 2;
      // Over-range sizes clamp to the maximum; run past two full lines so
      // interior medians come out at the widest line, then drop the rest.
      if (!wide_done && idle_stage == 2) begin
        wide_done = 1'b1;
        run_phase(1023, 8191, 2 * MAX_W + 12, 1'b0);
      end else begin
        random_phase();
      end
    end

    // One pixel wide with an over-range height: every pixel is border and
    // the row count runs against the clamped height; the frame is cut short.
    run_phase(0, 8191, 40, 1'b1);

    wait_quiet();
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin : watchdog
    #8_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
